### rtl/mlcd_pkg.sv
package mlcd_pkg;

  localparam int unsigned LastLine       = 487;
  localparam int unsigned LastDataLine   = 481;
  localparam int unsigned ClocksPerLine  = 123;
  localparam int unsigned EnableClock    = 122;
  localparam int unsigned LastPixelClock = 121;

  localparam logic [5:0] PlaneHigh = 6'b101010;
  localparam logic [5:0] PlaneLow  = 6'b010101;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncStep  = 1'b1;

  typedef struct packed {
    logic       interrupt_line;
    logic       gate_start;
    logic       gate_clock;
    logic       bit_start;
    logic       bit_clock;
    logic       gate_enable;
    logic       frame_last;
  } pins_t;

endpackage

### rtl/mip_lcd_scan_timing_generator.sv
// A step item's frame memory read and scan pins are registered first; the color pair is
// then formed from them into the output register, where the item's result appears.
// One item is accepted per cycle while the output is taken; write items give no result.
// Reset clears the scan state and the output stage asynchronously; the frame memory
// keeps no reset and holds undefined pixels until they are written.
module mip_lcd_scan_timing_generator #(
  parameter int PIXELS_PER_ROW = 240,
  parameter int ROW_COUNT      = 240
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [15:0] pixel_address_i,
  input  logic [5:0] pixel_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       interrupt_line_o,
  output logic       gate_start_o,
  output logic       gate_clock_o,
  output logic       bit_start_o,
  output logic       bit_clock_o,
  output logic       gate_enable_o,
  output logic [5:0] color_bus_o,
  output logic       frame_last_o
);
  import mlcd_pkg::*;

  localparam int Depth   = PIXELS_PER_ROW * ROW_COUNT;
  localparam int AW      = $clog2(Depth);
  localparam int PosMax  = 2 * (LastPixelClock - 1) + PIXELS_PER_ROW * ((LastDataLine - 2) / 2);
  localparam int PwA     = $clog2(Depth + 1);
  localparam int PwB     = $clog2(PosMax + 1);
  localparam int PwC     = (PwA > PwB) ? PwA : PwB;
  localparam int PW      = (PwC > 16) ? PwC : 16;

  typedef enum logic [1:0] {
    PhHead,
    PhClock,
    PhEnd,
    PhClose
  } phase_e;

  typedef struct packed {
    pins_t pins;
    logic  drive;
    logic  even;
    logic  oor0;
    logic  oor1;
  } stage_t;

  logic [5:0] mem_q [Depth];
  logic [5:0] rd0_q, rd1_q;

  phase_e     phase_q, phase_d;
  logic [8:0] line_q, line_d;
  logic [6:0] clock_q, clock_d;
  logic       busy_q, busy_d;
  logic       vtog_q, vtog_d;
  logic       htog_q, htog_d;
  logic       start_q, start_d;
  logic       rstart_q, rstart_d;
  logic       enable_q, enable_d;
  logic       irq_q, irq_d;
  logic       last_d;

  stage_t     s1_q, s1_d;
  logic       s1_valid_q;
  logic       out_valid_q;
  pins_t      out_pins_q;
  logic [5:0] color_q, color_d;

  logic          in_fire, step_fire, s1_go, drive;
  logic          wr_en;
  logic [PW-1:0] waddr, pos0, pos1;
  logic [6:0]    px;
  logic [8:0]    ly;
  logic [5:0]    p0, p1;

  assign in_fire   = in_valid_i && in_ready_o;
  assign step_fire = in_fire && (func_i == FuncStep);
  assign s1_go     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  assign waddr = PW'(pixel_address_i);
  assign wr_en = in_fire && (func_i == FuncWrite) && (waddr < PW'(Depth));

  assign px   = clock_q - 7'd2;
  assign ly   = line_q - 9'd2;
  assign pos0 = PW'({px, 1'b0}) + PW'(PIXELS_PER_ROW) * PW'(ly[8:1]);
  assign pos1 = pos0 + PW'(1);

  always_comb begin
    phase_d  = phase_q;
    line_d   = line_q;
    clock_d  = clock_q;
    busy_d   = busy_q;
    vtog_d   = vtog_q;
    htog_d   = htog_q;
    start_d  = start_q;
    rstart_d = rstart_q;
    enable_d = enable_q;
    irq_d    = irq_q;
    last_d   = 1'b0;
    drive    = 1'b0;
    if (!busy_q) begin
      busy_d  = 1'b1;
      irq_d   = 1'b1;
      start_d = 1'b1;
      vtog_d  = !vtog_q;
      line_d  = 9'd1;
      clock_d = 7'd0;
      phase_d = PhHead;
    end else begin
      case (phase_q)
        PhHead: begin
          if (line_q == 9'd1) begin
            start_d = 1'b0;
            phase_d = PhEnd;
          end else begin
            rstart_d = 1'b1;
            htog_d   = !htog_q;
            clock_d  = 7'd1;
            phase_d  = PhClock;
          end
        end
        PhClock: begin
          if (clock_q == 7'd1) rstart_d = 1'b0;
          if (clock_q == 7'(EnableClock)) begin
            enable_d = 1'b1;
          end else if (clock_q == 7'(ClocksPerLine)) begin
            enable_d = 1'b0;
          end
          drive  = clock_q inside {[7'd2 : 7'(LastPixelClock)]};
          htog_d = !htog_q;
          if (clock_q >= 7'(ClocksPerLine)) begin
            phase_d = PhEnd;
          end else begin
            clock_d = clock_q + 7'd1;
          end
        end
        PhEnd: begin
          vtog_d = !vtog_q;
          if (line_q >= 9'(LastLine)) begin
            phase_d = PhClose;
          end else begin
            line_d  = line_q + 9'd1;
            phase_d = (line_d <= 9'(LastDataLine)) ? PhHead : PhEnd;
          end
        end
        default: begin
          irq_d   = 1'b0;
          busy_d  = 1'b0;
          last_d  = 1'b1;
          line_d  = 9'd0;
          clock_d = 7'd0;
          phase_d = PhHead;
        end
      endcase
    end
  end

  always_comb begin
    s1_d.pins.interrupt_line = irq_d;
    s1_d.pins.gate_start     = start_d;
    s1_d.pins.gate_clock     = vtog_d;
    s1_d.pins.bit_start      = rstart_d;
    s1_d.pins.bit_clock      = htog_d;
    s1_d.pins.gate_enable    = enable_d;
    s1_d.pins.frame_last     = last_d;
    s1_d.drive               = drive;
    s1_d.even                = !line_q[0];
    s1_d.oor0                = pos0 >= PW'(Depth);
    s1_d.oor1                = pos1 >= PW'(Depth);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[waddr[AW-1:0]] <= pixel_value_i;
    if (step_fire && drive) begin
      rd0_q <= mem_q[pos0[AW-1:0]];
      rd1_q <= mem_q[pos1[AW-1:0]];
    end
  end

  assign p0 = s1_q.oor0 ? 6'd0 : rd0_q;
  assign p1 = s1_q.oor1 ? 6'd0 : rd1_q;

  always_comb begin
    color_d = color_q;
    if (s1_q.drive) begin
      if (s1_q.even) begin
        color_d = (p0 & PlaneHigh) | ((p1 & PlaneHigh) >> 1);
      end else begin
        color_d = ((p0 & PlaneLow) << 1) | (p1 & PlaneLow);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHead;
      line_q      <= '0;
      clock_q     <= '0;
      busy_q      <= 1'b0;
      vtog_q      <= 1'b0;
      htog_q      <= 1'b0;
      start_q     <= 1'b0;
      rstart_q    <= 1'b0;
      enable_q    <= 1'b0;
      irq_q       <= 1'b0;
      s1_q        <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_pins_q  <= '0;
      color_q     <= '0;
    end else begin
      if (step_fire) begin
        phase_q  <= phase_d;
        line_q   <= line_d;
        clock_q  <= clock_d;
        busy_q   <= busy_d;
        vtog_q   <= vtog_d;
        htog_q   <= htog_d;
        start_q  <= start_d;
        rstart_q <= rstart_d;
        enable_q <= enable_d;
        irq_q    <= irq_d;
        s1_q     <= s1_d;
      end
      if (step_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        out_valid_q <= 1'b1;
        out_pins_q  <= s1_q.pins;
        color_q     <= color_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign interrupt_line_o = out_pins_q.interrupt_line;
  assign gate_start_o     = out_pins_q.gate_start;
  assign gate_clock_o     = out_pins_q.gate_clock;
  assign bit_start_o      = out_pins_q.bit_start;
  assign bit_clock_o      = out_pins_q.bit_clock;
  assign gate_enable_o    = out_pins_q.gate_enable;
  assign color_bus_o      = color_q;
  assign frame_last_o     = out_pins_q.frame_last;

endmodule

### rtl/mlcd_checker.sv
module mlcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       func_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       interrupt_line_o,
  input logic       gate_start_o,
  input logic       gate_clock_o,
  input logic       bit_start_o,
  input logic       bit_clock_o,
  input logic       gate_enable_o,
  input logic [5:0] color_bus_o,
  input logic       frame_last_o
);
  import mlcd_pkg::*;

  a_close_drops_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_last_o) |-> (!interrupt_line_o && !gate_enable_o && !bit_start_o))
    else $error("closing item shows frame pins active");

  a_start_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !interrupt_line_o) |-> !gate_start_o)
    else $error("start pin high outside a frame");

  a_step_gives_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && func_i == FuncStep && !out_valid_o) |=> ##1 out_valid_o)
    else $error("step item gave no result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(color_bus_o)
      && $stable(gate_clock_o) && $stable(bit_clock_o)))
    else $error("stalled result changed");

endmodule

bind mip_lcd_scan_timing_generator mlcd_checker u_mlcd_checker (.*);
